>>> src/tpq_pkg.sv
// Shared constants for the triangle plane quadric pipeline.
package tpq_pkg;

	localparam int FIELD_W         = 32;
	localparam int OUT_W           = 64;
	localparam int OUT_FRAC        = 30;
	localparam int QUO_BITS        = 65;
	localparam int LIMB_W          = 32;
	localparam int N_ENTRY         = 10;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int COORD_FRAC_DEF  = 16;

endpackage

>>> src/triangle_plane_quadric.sv
// Top level of the triangle plane quadric pipeline with output skid buffer.
// One triangle enters per clock cycle while in_ready is high, and results leave in
// order, one per cycle while out_ready is high. The 65-stage restoring divider, one
// quotient bit per stage, sets most of the pipeline depth, and the two limb-serial
// multiplier banks (the cross product squares and the plane offset products) set
// the rest. Every entry is the exact plane quadric rounded to the nearest Q33.30
// code, ties away from zero, saturated to 64 bits. A triangle whose cross product
// is zero gives all entries zero with degenerate set.
module triangle_plane_quadric #(
	parameter int COORD_WIDTH     = tpq_pkg::COORD_WIDTH_DEF,
	parameter int COORD_FRAC_BITS = tpq_pkg::COORD_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tpq_pkg::FIELD_W-1:0] ax_coord,
	input  logic [tpq_pkg::FIELD_W-1:0] ay_coord,
	input  logic [tpq_pkg::FIELD_W-1:0] az_coord,
	input  logic [tpq_pkg::FIELD_W-1:0] bx_coord,
	input  logic [tpq_pkg::FIELD_W-1:0] by_coord,
	input  logic [tpq_pkg::FIELD_W-1:0] bz_coord,
	input  logic [tpq_pkg::FIELD_W-1:0] cx_coord,
	input  logic [tpq_pkg::FIELD_W-1:0] cy_coord,
	input  logic [tpq_pkg::FIELD_W-1:0] cz_coord,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tpq_pkg::OUT_W-1:0]   q_aa,
	output logic [tpq_pkg::OUT_W-1:0]   q_ab,
	output logic [tpq_pkg::OUT_W-1:0]   q_ac,
	output logic [tpq_pkg::OUT_W-1:0]   q_ad,
	output logic [tpq_pkg::OUT_W-1:0]   q_bb,
	output logic [tpq_pkg::OUT_W-1:0]   q_bc,
	output logic [tpq_pkg::OUT_W-1:0]   q_bd,
	output logic [tpq_pkg::OUT_W-1:0]   q_cc,
	output logic [tpq_pkg::OUT_W-1:0]   q_cd,
	output logic [tpq_pkg::OUT_W-1:0]   q_dd,
	output logic                        degenerate
);

	localparam int CW      = COORD_WIDTH;
	localparam int CF      = COORD_FRAC_BITS;
	localparam int OW      = tpq_pkg::OUT_W;
	localparam int NE      = tpq_pkg::N_ENTRY;
	localparam int LW      = tpq_pkg::LIMB_W;
	localparam int OF      = tpq_pkg::OUT_FRAC;
	localparam int EW      = CW + 1;
	localparam int P2W     = 2 * EW;
	localparam int CRW     = P2W + 1;
	localparam int CMW     = CRW - 1;
	localparam int PAW     = 2 * CMW;
	localparam int TSW     = 3 * CW + 3;
	localparam int TMW     = TSW - 1;
	localparam int PBW     = 2 * TMW;
	localparam int LAT_A   = (CMW + LW - 1) / LW + 1;
	localparam int LAT_B   = (TMW + LW - 1) / LW + 1;
	localparam int DB      = 7 + LAT_A + LAT_B;
	localparam int LAT_D   = tpq_pkg::QUO_BITS + 3;
	localparam int LAT_TOT = DB + LAT_D;
	localparam int SH1     = OF - CF;
	localparam int SH2     = OF - 2 * CF;
	localparam int SH2P    = (SH2 > 0) ? SH2 : 0;
	localparam int DSH     = (SH2 < 0) ? -SH2 : 0;
	localparam int NW      = PBW + OF;
	localparam int DW      = PAW + DSH;

	logic                 en;
	logic [LAT_TOT-1:0]   vld_q;
	logic                 last_vld;

	logic [CW-1:0]        a_in [3];
	logic [CW-1:0]        b_in [3];
	logic [CW-1:0]        c_in [3];

	logic [CW-1:0]        a_s1 [3];
	logic signed [EW-1:0] e_s1 [3];
	logic signed [EW-1:0] f_s1 [3];
	logic [CW-1:0]        a_s2 [3];
	logic signed [P2W-1:0] p_s2 [6];
	logic [CW-1:0]        a_s3 [3];
	logic [CRW-1:0]       c_s3 [3];
	logic [CRW-1:0]       c_abs [3];
	logic [CW-1:0]        a_abs [3];
	logic [CMW-1:0]       cmag_s4 [3];
	logic [CW-1:0]        amag_s4 [3];
	logic [2:0]           cneg_s4;
	logic [2:0]           aneg_s4;

	logic [CMW-1:0]       opa [9];
	logic [CMW-1:0]       opb [9];
	logic [PAW-1:0]       pa [9];
	logic [2:0]           cas_d;

	logic [PAW-1:0]       s_sx1;
	logic [TSW-1:0]       ta_sx1 [3];
	logic [TSW-1:0]       tm [3];
	logic [TSW-1:0]       t_sx2;
	logic [PAW-1:0]       s_sx2;
	logic                 deg_sx2;
	logic [TSW-1:0]       t_abs;
	logic [TMW-1:0]       tmag_sx3;
	logic                 tneg_sx3;
	logic [PAW-1:0]       s_sx3;
	logic                 deg_sx3;

	logic [3*CMW-1:0]     cmv_in;
	logic [3*CMW-1:0]     cmv_out;
	logic [TMW-1:0]       opc [4];
	logic [TMW-1:0]       opd [4];
	logic [PBW-1:0]       pb [4];

	logic [6*PAW-1:0]     ccv_in;
	logic [6*PAW-1:0]     ccv_out;
	logic [PAW-1:0]       ccm [6];
	logic [2:0]           cs_d;
	logic [PAW+1:0]       side_in;
	logic [PAW+1:0]       side_out;
	logic [PAW-1:0]       s_d;
	logic                 tn_d;
	logic                 deg_d;
	logic                 deg_o;

	logic [NW-1:0]        num [NE];
	logic [DW-1:0]        den [NE];
	logic [NE-1:0]        sgn;
	logic [OW-1:0]        quo [NE];
	logic [OW-1:0]        res [NE];

	logic                 take_out;
	logic                 out_vld_q;
	logic                 skid_vld_q;
	logic [OW-1:0]        out_q [NE];
	logic [OW-1:0]        skid_q [NE];
	logic                 deg_out_q;
	logic                 deg_skid_q;

	assign en       = ~skid_vld_q;
	assign in_ready = en;
	assign last_vld = vld_q[LAT_TOT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT_TOT-2:0], in_valid};
		end
	end

	assign a_in[0] = ax_coord[CW-1:0];
	assign a_in[1] = ay_coord[CW-1:0];
	assign a_in[2] = az_coord[CW-1:0];
	assign b_in[0] = bx_coord[CW-1:0];
	assign b_in[1] = by_coord[CW-1:0];
	assign b_in[2] = bz_coord[CW-1:0];
	assign c_in[0] = cx_coord[CW-1:0];
	assign c_in[1] = cy_coord[CW-1:0];
	assign c_in[2] = cz_coord[CW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= a_in[i];
				e_s1[i] <= {b_in[i][CW-1], b_in[i]} - {a_in[i][CW-1], a_in[i]};
				f_s1[i] <= {c_in[i][CW-1], c_in[i]} - {a_in[i][CW-1], a_in[i]};
			end
			a_s2    <= a_s1;
			p_s2[0] <= e_s1[1] * f_s1[2];
			p_s2[1] <= e_s1[2] * f_s1[1];
			p_s2[2] <= e_s1[2] * f_s1[0];
			p_s2[3] <= e_s1[0] * f_s1[2];
			p_s2[4] <= e_s1[0] * f_s1[1];
			p_s2[5] <= e_s1[1] * f_s1[0];
			a_s3    <= a_s2;
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= {p_s2[2*i][P2W-1], p_s2[2*i]}
					- {p_s2[2*i+1][P2W-1], p_s2[2*i+1]};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_abs[i] = c_s3[i][CRW-1] ? ~c_s3[i] + 1'b1 : c_s3[i];
			a_abs[i] = a_s3[i][CW-1] ? ~a_s3[i] + 1'b1 : a_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cmag_s4[i] <= c_abs[i][CMW-1:0];
				amag_s4[i] <= a_abs[i];
				cneg_s4[i] <= c_s3[i][CRW-1];
				aneg_s4[i] <= a_s3[i][CW-1];
			end
		end
	end

	// Squares and cross terms of the normal, then the normal against corner A.
	assign opa[0] = cmag_s4[0];
	assign opb[0] = cmag_s4[0];
	assign opa[1] = cmag_s4[0];
	assign opb[1] = cmag_s4[1];
	assign opa[2] = cmag_s4[0];
	assign opb[2] = cmag_s4[2];
	assign opa[3] = cmag_s4[1];
	assign opb[3] = cmag_s4[1];
	assign opa[4] = cmag_s4[1];
	assign opb[4] = cmag_s4[2];
	assign opa[5] = cmag_s4[2];
	assign opb[5] = cmag_s4[2];
	assign opa[6] = cmag_s4[0];
	assign opb[6] = CMW'(amag_s4[0]);
	assign opa[7] = cmag_s4[1];
	assign opb[7] = CMW'(amag_s4[1]);
	assign opa[8] = cmag_s4[2];
	assign opb[8] = CMW'(amag_s4[2]);

	for (genvar m = 0; m < 9; m++) begin : g_mul_a
		tpq_mul #(
			.AW(CMW),
			.BW(CMW)
		) u_mul (
			.clk(clk),
			.en (en),
			.a  (opa[m]),
			.b  (opb[m]),
			.p  (pa[m])
		);
	end

	tpq_dly #(
		.W(3),
		.D(LAT_A)
	) u_dly_cas (
		.clk(clk),
		.en (en),
		.d  (cneg_s4 ^ aneg_s4),
		.q  (cas_d)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tm[i] = TSW'(pa[6+i]);
		end
		t_abs = t_sx2[TSW-1] ? ~t_sx2 + 1'b1 : t_sx2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_sx1 <= pa[0] + pa[3] + pa[5];
			for (int i = 0; i < 3; i++) begin
				ta_sx1[i] <= cas_d[i] ? ~tm[i] + 1'b1 : tm[i];
			end
			t_sx2    <= ta_sx1[0] + ta_sx1[1] + ta_sx1[2];
			s_sx2    <= s_sx1;
			deg_sx2  <= s_sx1 == '0;
			tmag_sx3 <= t_abs[TMW-1:0];
			tneg_sx3 <= t_sx2[TSW-1];
			s_sx3    <= s_sx2;
			deg_sx3  <= deg_sx2;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_pack_c
		assign cmv_in[i*CMW +: CMW] = cmag_s4[i];
		assign opc[i]               = TMW'(cmv_out[i*CMW +: CMW]);
		assign opd[i]               = tmag_sx3;
	end
	assign opc[3] = tmag_sx3;
	assign opd[3] = tmag_sx3;

	tpq_dly #(
		.W(3 * CMW),
		.D(3 + LAT_A)
	) u_dly_cmag (
		.clk(clk),
		.en (en),
		.d  (cmv_in),
		.q  (cmv_out)
	);

	for (genvar m = 0; m < 4; m++) begin : g_mul_b
		tpq_mul #(
			.AW(TMW),
			.BW(TMW)
		) u_mul (
			.clk(clk),
			.en (en),
			.a  (opc[m]),
			.b  (opd[m]),
			.p  (pb[m])
		);
	end

	for (genvar i = 0; i < 6; i++) begin : g_pack_cc
		assign ccv_in[i*PAW +: PAW] = pa[i];
		assign ccm[i]               = ccv_out[i*PAW +: PAW];
	end

	tpq_dly #(
		.W(6 * PAW),
		.D(3 + LAT_B)
	) u_dly_cc (
		.clk(clk),
		.en (en),
		.d  (ccv_in),
		.q  (ccv_out)
	);

	tpq_dly #(
		.W(3),
		.D(DB - 4)
	) u_dly_cs (
		.clk(clk),
		.en (en),
		.d  (cneg_s4),
		.q  (cs_d)
	);

	assign side_in = {deg_sx3, tneg_sx3, s_sx3};

	tpq_dly #(
		.W(PAW + 2),
		.D(LAT_B)
	) u_dly_side (
		.clk(clk),
		.en (en),
		.d  (side_in),
		.q  (side_out)
	);

	assign s_d   = side_out[PAW-1:0];
	assign tn_d  = side_out[PAW];
	assign deg_d = side_out[PAW+1];

	// Entries in output order: aa ab ac ad bb bc bd cc cd dd.
	always_comb begin
		num[0] = NW'(ccm[0]) << OF;
		num[1] = NW'(ccm[1]) << OF;
		num[2] = NW'(ccm[2]) << OF;
		num[3] = NW'(pb[0]) << SH1;
		num[4] = NW'(ccm[3]) << OF;
		num[5] = NW'(ccm[4]) << OF;
		num[6] = NW'(pb[1]) << SH1;
		num[7] = NW'(ccm[5]) << OF;
		num[8] = NW'(pb[2]) << SH1;
		num[9] = NW'(pb[3]) << SH2P;
		for (int i = 0; i < NE - 1; i++) begin
			den[i] = DW'(s_d);
		end
		den[NE-1] = DW'(s_d) << DSH;
		sgn[0] = 1'b0;
		sgn[1] = cs_d[0] ^ cs_d[1];
		sgn[2] = cs_d[0] ^ cs_d[2];
		sgn[3] = ~(cs_d[0] ^ tn_d);
		sgn[4] = 1'b0;
		sgn[5] = cs_d[1] ^ cs_d[2];
		sgn[6] = ~(cs_d[1] ^ tn_d);
		sgn[7] = 1'b0;
		sgn[8] = ~(cs_d[2] ^ tn_d);
		sgn[9] = 1'b0;
	end

	for (genvar m = 0; m < NE; m++) begin : g_div
		tpq_div #(
			.NW(NW),
			.DW(DW)
		) u_div (
			.clk(clk),
			.en (en),
			.num(num[m]),
			.den(den[m]),
			.neg(sgn[m]),
			.quo(quo[m])
		);
	end

	tpq_dly #(
		.W(1),
		.D(LAT_D)
	) u_dly_deg (
		.clk(clk),
		.en (en),
		.d  (deg_d),
		.q  (deg_o)
	);

	always_comb begin
		for (int i = 0; i < NE; i++) begin
			res[i] = deg_o ? '0 : quo[i];
		end
	end

	assign take_out = ~out_vld_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take_out) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= last_vld;
			end
		end else if (last_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			if (skid_vld_q) begin
				out_q     <= skid_q;
				deg_out_q <= deg_skid_q;
			end else begin
				out_q     <= res;
				deg_out_q <= deg_o;
			end
		end else if (last_vld && en) begin
			skid_q     <= res;
			deg_skid_q <= deg_o;
		end
	end

	assign out_valid  = out_vld_q;
	assign q_aa       = out_q[0];
	assign q_ab       = out_q[1];
	assign q_ac       = out_q[2];
	assign q_ad       = out_q[3];
	assign q_bb       = out_q[4];
	assign q_bc       = out_q[5];
	assign q_bd       = out_q[6];
	assign q_cc       = out_q[7];
	assign q_cd       = out_q[8];
	assign q_dd       = out_q[9];
	assign degenerate = deg_out_q;

endmodule

>>> src/tpq_dly.sv
// Stallable delay line for side data that travels beside the arithmetic units.
module tpq_dly #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_s [D];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= d;
			for (int i = 1; i < D; i++) begin
				pipe_s[i] <= pipe_s[i-1];
			end
		end
	end

	assign q = pipe_s[D-1];

endmodule

>>> src/tpq_mul.sv
// Pipelined unsigned multiplier built from registered limb products and row adds.
module tpq_mul #(
	parameter int AW = 66,
	parameter int BW = 66
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] p
);

	localparam int LW  = tpq_pkg::LIMB_W;
	localparam int LA  = (AW + LW - 1) / LW;
	localparam int LB  = (BW + LW - 1) / LW;
	localparam int AXW = LA * LW;
	localparam int BXW = LB * LW;
	localparam int RW  = (LA + 1) * LW;
	localparam int ACW = (LA + LB) * LW;

	logic [AXW-1:0]    a_x;
	logic [BXW-1:0]    b_x;
	logic [2*LW-1:0]   pp_s  [LB][LB][LA];
	logic [ACW-1:0]    acc_s [LB];

	assign a_x = AXW'(a);
	assign b_x = BXW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < LB; j++) begin
				for (int i = 0; i < LA; i++) begin
					pp_s[0][j][i] <= a_x[i*LW +: LW] * b_x[j*LW +: LW];
				end
			end
		end
	end

	for (genvar k = 0; k < LB; k++) begin : g_row
		logic [RW-1:0]  row_e;
		logic [RW-1:0]  row_o;
		logic [ACW-1:0] acc_prev;

		if (k == 0) begin : g_first
			assign acc_prev = '0;
		end else begin : g_next
			assign acc_prev = acc_s[k-1];
		end

		always_comb begin
			row_e = '0;
			row_o = '0;
			for (int i = 0; i < LA; i++) begin
				if (i % 2 == 0) begin
					row_e[i*LW +: 2*LW] = pp_s[k][k][i];
				end else begin
					row_o[i*LW +: 2*LW] = pp_s[k][k][i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k] <= acc_prev + (ACW'(row_e) << (k * LW)) + (ACW'(row_o) << (k * LW));
			end
		end

		if (k < LB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s[k+1] <= pp_s[k];
				end
			end
		end
	end

	assign p = acc_s[LB-1][AW+BW-1:0];

endmodule

>>> src/tpq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
module tpq_div #(
	parameter int NW = 226,
	parameter int DW = 132
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [NW-1:0]            num,
	input  logic [DW-1:0]            den,
	input  logic                     neg,
	output logic [tpq_pkg::OUT_W-1:0] quo
);

	localparam int QB  = tpq_pkg::QUO_BITS;
	localparam int OW  = tpq_pkg::OUT_W;
	localparam int XW  = (NW > DW + QB) ? NW : DW + QB;
	localparam int RCW = ((NW > DW) ? NW : DW) + 1;

	logic [NW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [QB:0]   neg_s;
	logic [QB:0]   ovf_s;

	logic          rnd_up;
	logic [QB:0]   mag_sr;
	logic          neg_sr;
	logic          ovf_sr;
	logic [QB:0]   lim;
	logic [QB:0]   mag_sat;
	logic [OW-1:0] quo_sf;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= XW'(num >> QB) >= XW'(den);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int BIT = QB - 1 - k;
		logic [XW-1:0] sub;
		logic          take;

		always_comb begin
			sub  = XW'(den_s[k]) << BIT;
			take = XW'(rem_s[k]) >= sub;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]   <= take ? NW'(XW'(rem_s[k]) - sub) : rem_s[k];
				den_s[k+1]   <= den_s[k];
				quo_s[k+1]   <= quo_s[k] | (QB'(take) << BIT);
				neg_s[k+1]   <= neg_s[k];
				ovf_s[k+1]   <= ovf_s[k];
			end
		end
	end

	assign rnd_up = (RCW'(rem_s[QB]) << 1) >= RCW'(den_s[QB]);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_sr <= (QB+1)'(quo_s[QB]) + (QB+1)'(rnd_up);
			neg_sr <= neg_s[QB];
			ovf_sr <= ovf_s[QB];
		end
	end

	always_comb begin
		lim = (QB+1)'(1) << (OW - 1);
		if (!neg_sr) begin
			lim = lim - 1'b1;
		end
		mag_sat = (ovf_sr || mag_sr > lim) ? lim : mag_sr;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_sf <= neg_sr ? OW'(~mag_sat + 1'b1) : OW'(mag_sat);
		end
	end

	assign quo = quo_sf;

endmodule
